@@ hw/rtl/ready_queue_with_id_removal_macros.svh @@
// assertion macros for the ready queue block
// included by the modules that carry concurrent assertions
`ifndef READY_QUEUE_WITH_ID_REMOVAL_MACROS_SVH
`define READY_QUEUE_WITH_ID_REMOVAL_MACROS_SVH

// same-cycle implication
`define RQIR_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RQIR_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rqir_pkg.sv @@
// shared types and constants for the ready queue block
// no dependencies
package rqir_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    localparam int OP_W        = 2;
    localparam int KEY_W       = 16;
    localparam int HANDLE_BITS = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POP   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

@@ hw/rtl/ready_queue_with_id_removal.sv @@
// ready queue top level: control sequencer around one entry ram
// depends on rqir_pkg, rqir_ram and ready_queue_with_id_removal_macros.svh
//
// Usage: one transaction on the s_ channel carries an operation (insert, pop
// oldest, lookup by id, remove by id), a key id and a handle. Exactly one
// transaction comes back on the m_ channel with status, the found handle and
// id, and the fill level after the operation. Entries live in a single ram
// of QUEUE_DEPTH words (id and handle), kept as a circular buffer.
// From acceptance to m_valid: insert writes the ram and finishes, pop reads
// the oldest entry, lookup searches newest first, and remove searches, then
// closes the gap with one entry moved per cycle.
// The single read port of the ram sets the rate: the search reads one entry
// per cycle, newest first, and the gap close copies one entry per cycle.
// One operation is in flight at a time; s_ready is high while the sequencer
// is idle, also while an earlier result still waits in the output register.
// s_ready returns with m_valid, so no insert is taken while the last one is in flight.
// If the receiver stalls, the finished result waits until the output
// register frees, then the next transaction is taken.
// Synchronous reset empties the queue; ram contents are left as they are.
module ready_queue_with_id_removal #(
    parameter int QUEUE_DEPTH  = rqir_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = rqir_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rqir_pkg::OP_W-1:0]        s_operation,
    input  logic [rqir_pkg::KEY_W-1:0]       s_key_id,
    input  logic [rqir_pkg::HANDLE_BITS-1:0] s_handle,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rqir_pkg::STATUS_W-1:0]    m_status,
    output logic [rqir_pkg::HANDLE_BITS-1:0] m_out_handle,
    output logic [rqir_pkg::KEY_W-1:0]       m_out_id,
    output logic [rqir_pkg::FILL_W-1:0]      m_fill_level
);

    import rqir_pkg::*;

    `include "ready_queue_with_id_removal_macros.svh"

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_W = (HANDLE_WIDTH < HANDLE_BITS) ? HANDLE_WIDTH : HANDLE_BITS;
    localparam int DW      = KEY_W + STORE_W;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     fill_count_reg, fill_count_next;
    logic [AW-1:0]        oldest_reg, oldest_next;
    logic                 remove_reg, remove_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 issue_reg, issue_next;
    logic [AW-1:0]        dpos_reg, dpos_next;
    logic                 dvalid_reg, dvalid_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [STORE_W-1:0]   res_handle_reg, res_handle_next;
    logic [KEY_W-1:0]     res_id_reg, res_id_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [STORE_W-1:0]   m_handle_reg, m_handle_next;
    logic [KEY_W-1:0]     m_id_reg, m_id_next;
    logic [FILL_W-1:0]    m_fill_reg, m_fill_next;

    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [DW-1:0]        ram_wr_data;
    logic                 ram_rd_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [DW-1:0]        ram_rd_data;

    logic                 accept;
    logic                 out_free;
    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        last_pos;
    logic [KEY_W-1:0]     rd_id;
    logic [STORE_W-1:0]   rd_handle;

    rqir_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_full   = (fill_count_reg >= CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (fill_count_reg == '0);
    assign last_pos  = AW'(fill_count_reg - 1'b1);
    assign rd_id     = ram_rd_data[DW-1 -: KEY_W];
    assign rd_handle = ram_rd_data[STORE_W-1:0];

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        oldest_next     = oldest_reg;
        remove_next     = remove_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        issue_next      = issue_reg;
        dpos_next       = dpos_reg;
        dvalid_next     = dvalid_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_id_next     = res_id_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_handle_next   = m_handle_reg;
        m_id_next       = m_id_reg;
        m_fill_next     = m_fill_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_of(oldest_reg, AW'(fill_count_reg));
        ram_wr_data     = {s_key_id, s_handle[STORE_W-1:0]};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_of(oldest_reg, pos_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next        = s_key_id;
                    remove_next     = (op_t'(s_operation) == OP_REMOVE);
                    res_status_next = STAT_OK;
                    res_handle_next = '0;
                    res_id_next     = '0;
                    case (op_t'(s_operation))
                        OP_INSERT: begin
                            if (is_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ram_wr_en       = 1'b1;
                                fill_count_next = fill_count_reg + 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                res_status_next = STAT_MISS;
                                state_next      = ST_DONE;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = oldest_reg;
                                state_next  = ST_POP;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                res_status_next = STAT_MISS;
                                state_next      = ST_DONE;
                            end else begin
                                pos_next    = last_pos;
                                issue_next  = 1'b1;
                                dvalid_next = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_POP: begin
                res_handle_next = rd_handle;
                res_id_next     = rd_id;
                oldest_next     = (oldest_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : oldest_reg + 1'b1;
                fill_count_next = fill_count_reg - 1'b1;
                state_next      = ST_DONE;
            end

            ST_SCAN: begin
                // newest-first search, one read issued per cycle
                ram_rd_en   = issue_reg;
                dvalid_next = issue_reg;
                dpos_next   = pos_reg;
                if (issue_reg) begin
                    if (pos_reg == '0) begin
                        issue_next = 1'b0;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
                if (dvalid_reg) begin
                    if (rd_id == key_reg) begin
                        res_handle_next = rd_handle;
                        res_id_next     = rd_id;
                        if (!remove_reg) begin
                            state_next = ST_DONE;
                        end else if (dpos_reg == last_pos) begin
                            fill_count_next = fill_count_reg - 1'b1;
                            state_next      = ST_DONE;
                        end else begin
                            pos_next    = dpos_reg + 1'b1;
                            issue_next  = 1'b1;
                            dvalid_next = 1'b0;
                            state_next  = ST_SHIFT;
                        end
                    end else if (dpos_reg == '0) begin
                        res_status_next = STAT_MISS;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_SHIFT: begin
                // read entry j+1 while writing entry j, read in the previous cycle, one slot down
                ram_rd_en   = issue_reg;
                dvalid_next = issue_reg;
                dpos_next   = pos_reg - 1'b1;
                if (issue_reg) begin
                    if (pos_reg == last_pos) begin
                        issue_next = 1'b0;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                if (dvalid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = slot_of(oldest_reg, dpos_reg);
                    ram_wr_data = ram_rd_data;
                end
                if (!issue_reg && !dvalid_reg) begin
                    fill_count_next = fill_count_reg - 1'b1;
                    state_next      = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_handle_next = res_handle_reg;
                    m_id_next     = res_id_reg;
                    m_fill_next   = FILL_W'(fill_count_reg);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            oldest_reg     <= '0;
            issue_reg      <= 1'b0;
            dvalid_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            oldest_reg     <= oldest_next;
            issue_reg      <= issue_next;
            dvalid_reg     <= dvalid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        remove_reg     <= remove_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        dpos_reg       <= dpos_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_id_reg     <= res_id_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
        m_id_reg       <= m_id_next;
        m_fill_reg     <= m_fill_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_handle = HANDLE_BITS'(m_handle_reg);
    assign m_out_id     = m_id_reg;
    assign m_fill_level = m_fill_reg;

    `RQIR_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1,
        fill_count_reg <= CNT_W'(QUEUE_DEPTH), "fill count beyond queue depth")
    `RQIR_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept,
        state_reg != ST_IDLE, "sequencer idle right after a transaction")
    `RQIR_ASSERT_NEXT(a_insert_grows, aclk, aresetn,
        accept && (op_t'(s_operation) == OP_INSERT) && !is_full,
        fill_count_reg == CNT_W'($past(fill_count_reg) + 1'b1), "insert did not add an entry")
    `RQIR_ASSERT_NEXT(a_done_emits, aclk, aresetn, (state_reg == ST_DONE) && out_free,
        m_valid_reg && (state_reg == ST_IDLE), "finished result not presented")

endmodule

@@ hw/rtl/rqir_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rqir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
